>>> sv/utf8d_pkg.sv
package utf8d_pkg;

   localparam int unsigned CODE_POINT_WIDTH = 21;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] LEAD_TWO_LAST = 8'hDF;
   localparam logic [7:0] LEAD_THREE_LAST = 8'hEF;
   localparam logic [7:0] LEAD_FOUR_LAST = 8'hF7;
   localparam logic [7:0] LEAD_SURROGATE = 8'hED;
   localparam logic [1:0] CONT_TAG = 2'b10;
   localparam logic [2:0] SURROGATE_TAG = 3'b101;

   typedef struct packed {
      logic [CODE_POINT_WIDTH-1:0] code_point;
      logic invalid;
      logic string_last;
      logic run_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } group_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

>>> sv/utf8d_front.sv
module utf8d_front
   import utf8d_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       byte_in,
   input  logic             string_end,
   output logic             group_push,
   output group_type        group_out
);

   logic [1:0] need_ff, need_in;
   logic [CODE_POINT_WIDTH-1:0] code_ff, code_in;
   logic ed_ff, ed_in;
   logic fresh_ff, fresh_in;
   result_type em [2];
   logic [1:0] cnt;

   always_comb begin
      need_in = need_ff;
      code_in = code_ff;
      ed_in = ed_ff;
      fresh_in = fresh_ff;
      cnt = 2'd0;
      em[0] = '0;
      em[1] = '0;

      if (byte_in[7:6] == CONT_TAG) begin
         if (need_ff != 2'd0) begin
            if (ed_ff && byte_in[7:5] == SURROGATE_TAG) begin
               em[cnt[0]].invalid = 1'b1;
               cnt = cnt + 2'd1;
               need_in = 2'd0;
            end else begin
               code_in = {code_ff[CODE_POINT_WIDTH-7:0], byte_in[5:0]};
               need_in = need_ff - 2'd1;
               if (need_in == 2'd0) begin
                  em[cnt[0]].code_point = code_in;
                  cnt = cnt + 2'd1;
               end
            end
            ed_in = 1'b0;
         end else if (fresh_ff) begin
            em[cnt[0]].invalid = 1'b1;
            cnt = cnt + 2'd1;
         end
      end else begin
         if (need_ff != 2'd0) begin
            em[cnt[0]].invalid = 1'b1;
            cnt = cnt + 2'd1;
         end
         need_in = 2'd0;
         ed_in = 1'b0;
         priority if (!byte_in[7]) begin
            em[cnt[0]].code_point = CODE_POINT_WIDTH'(byte_in);
            cnt = cnt + 2'd1;
         end else if (byte_in <= LEAD_TWO_LAST) begin
            need_in = 2'd1;
            code_in = CODE_POINT_WIDTH'(byte_in[4:0]);
         end else if (byte_in <= LEAD_THREE_LAST) begin
            need_in = 2'd2;
            code_in = CODE_POINT_WIDTH'(byte_in[3:0]);
            ed_in = (byte_in == LEAD_SURROGATE);
         end else if (byte_in <= LEAD_FOUR_LAST) begin
            need_in = 2'd3;
            code_in = CODE_POINT_WIDTH'(byte_in[2:0]);
         end else begin
            em[cnt[0]].invalid = 1'b1;
            cnt = cnt + 2'd1;
         end
      end

      if (string_end) begin
         if (need_in != 2'd0) begin
            em[cnt[0]].invalid = 1'b1;
            cnt = cnt + 2'd1;
         end
         need_in = 2'd0;
         ed_in = 1'b0;
         fresh_in = 1'b1;
         if (cnt != 2'd0) begin
            em[cnt[1]].string_last = 1'b1;
         end
      end else begin
         fresh_in = 1'b0;
      end

      if (cnt != 2'd0) begin
         em[cnt[1]].run_last = 1'b1;
      end
   end

   assign group_push = accept && (cnt != 2'd0);
   assign group_out = '{count: cnt, first: em[0], second: em[1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff <= 2'd0;
         code_ff <= '0;
         ed_ff <= 1'b0;
         fresh_ff <= 1'b1;
      end else if (accept) begin
         need_ff <= need_in;
         code_ff <= code_in;
         ed_ff <= ed_in;
         fresh_ff <= fresh_in;
      end
   end

endmodule

>>> sv/utf8d_queue.sv
module utf8d_queue
   import utf8d_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  group_type        wr_data,
   input  logic             rd_en,
   output group_type        rd_data,
   output queue_status_type status
);

   localparam int unsigned PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(QUEUE_DEPTH);

   group_type mem_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign status.empty = (count_ff == '0);
   assign status.full = (count_ff == CountFull);
   assign do_wr = wr_en && !status.full;
   assign do_rd = rd_en && !status.empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_wr, do_rd})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> sv/utf8d_back.sv
module utf8d_back
   import utf8d_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  group_type        q_data,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output result_type       result
);

   group_type group_ff;
   logic valid_ff, valid_in;
   logic sel_ff, sel_in;
   logic last_of_group;
   logic take_next;

   assign last_of_group = sel_ff || (group_ff.count == 2'd1);
   assign take_next = !valid_ff || (pop && last_of_group);
   assign q_pop = take_next && !q_status.empty;
   assign empty = !valid_ff;
   assign result = sel_ff ? group_ff.second : group_ff.first;

   always_comb begin
      valid_in = valid_ff;
      sel_in = sel_ff;
      if (take_next) begin
         valid_in = !q_status.empty;
         sel_in = 1'b0;
      end else if (pop) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         group_ff <= q_data;
      end
   end

endmodule

>>> sv/utf8_stream_decoder.sv
// Decodes a UTF-8 string that arrives one byte per transaction, with
// req_string_end marking the final byte, into code points of up to 21 bits.
// One byte is accepted every cycle while full is low. A byte gives zero, one
// or two results (an error for a character cut short, then its own result),
// and the result side delivers one result per cycle while pop is high, so
// a run of bytes that each give two results is limited by the output to one
// result per cycle. A result reaches the result ports through registers:
// the decoding stage writes a small queue of per-byte result groups at the
// accepting edge, and the output stage loads one group at a time from it
// into its own register, which drives the result ports.
module utf8_stream_decoder
   import utf8d_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [7:0]                  req_byte_in,
   input  logic                        req_string_end,
   output logic                        empty,
   input  logic                        pop,
   output logic [CODE_POINT_WIDTH-1:0] rsp_code_point,
   output logic                        rsp_invalid,
   output logic                        rsp_string_last,
   output logic                        rsp_run_last
);

   queue_status_type q_status;
   group_type front_group;
   group_type q_data;
   logic front_push;
   logic q_pop;
   logic accept;
   result_type result;

   assign full = q_status.full;
   assign accept = push && !q_status.full;

   utf8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_in    (req_byte_in),
      .string_end (req_string_end),
      .group_push (front_push),
      .group_out  (front_group)
   );

   utf8d_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_data (front_group),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .status  (q_status)
   );

   utf8d_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .pop      (pop),
      .empty    (empty),
      .result   (result)
   );

   assign rsp_code_point = result.code_point;
   assign rsp_invalid = result.invalid;
   assign rsp_string_last = result.string_last;
   assign rsp_run_last = result.run_last;

endmodule

>>> sv/utf8d_checker.sv
module utf8d_checker
   import utf8d_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        full,
   input  logic                        empty,
   input  logic                        pop,
   input  logic [CODE_POINT_WIDTH-1:0] rsp_code_point,
   input  logic                        rsp_invalid,
   input  logic                        rsp_string_last,
   input  logic                        rsp_run_last
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("Result side not empty after reset.");

   a_not_full_after_reset: assert property (@(posedge clock) reset |=> !full)
      else $error("Input side full after reset.");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_invalid) |-> (rsp_code_point == '0))
      else $error("Invalid result carries a nonzero code point.");

   a_string_last_run_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_string_last) |-> rsp_run_last)
      else $error("Final result of a string is not the last result of its byte.");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_code_point) && $stable(rsp_invalid)))
      else $error("Waiting result changed before it was taken.");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (.*);
